FILE: hdl/v2dc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid 2D convolution: shared definitions
// Field widths, register map, reset values and the payload types of the
// pixel and result channels.
// ----------------------------------------------------------------------------
package v2dc_pkg;

    localparam int PIXEL_BITS         = 16;
    localparam int COEF_BITS          = 16;
    localparam int COEF_ROWS          = 4;
    localparam int COEF_COLS          = 4;
    localparam int SUM_BITS           = 36;
    localparam int IDX_BITS           = 10;
    localparam int DIM_BITS           = 11;
    localparam int KSIZE_BITS         = 3;
    localparam int MAX_HEIGHT         = 1024;
    localparam int MAX_KERNEL_DEFAULT = 4;
    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int CFG_DATA_BITS      = 64;
    localparam int CFG_ADDR_BITS      = 6;

    localparam logic [KSIZE_BITS-1:0] KERNEL_ROWS_RESET  = 3'd3;
    localparam logic [KSIZE_BITS-1:0] KERNEL_COLS_RESET  = 3'd3;
    localparam logic [DIM_BITS-1:0]   IMAGE_WIDTH_RESET  = 11'd768;
    localparam logic [DIM_BITS-1:0]   IMAGE_HEIGHT_RESET = 11'd768;

    typedef enum logic [2:0] {
        REG_KERNEL_ROWS  = 3'd0,
        REG_KERNEL_COLS  = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3,
        REG_KERNEL_ROW_0 = 3'd4,
        REG_KERNEL_ROW_1 = 3'd5,
        REG_KERNEL_ROW_2 = 3'd6,
        REG_KERNEL_ROW_3 = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] pixel;
        logic                         frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic [IDX_BITS-1:0]        out_row;
        logic [IDX_BITS-1:0]        out_col;
        logic                       last;
        logic                       error;
    } t_result;

endpackage

FILE: hdl/v2dc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module v2dc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/valid_2d_convolution.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid 2D convolution over a raster pixel stream
// Line store in RAM, window of recent columns, pipelined multiply-accumulate.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (i_in_valid / o_in_stall) in raster order,
// one transfer per clock unless stalled. Each pixel that closes a complete
// window gives one result transfer on the output channel (o_out_valid /
// i_out_stall) with the Q20.16 window sum, its output row and column and a
// last flag. A pixel with frame_start whose image size is not a multiple of
// the kernel size gives a single result with error set, and the rest of that
// frame gives none. Results pass the line store, window, product, row sum and
// output registers; throughput is one pixel per clock unless stalled, set by
// the single read-modify-write of a column word in the line store RAM (all
// stored rows of one column share a word). Kernel size and image size are
// registers on the APB-style port. After reset and after every register write
// the divisibility check runs bit-serially over the 11 bits of the widest image
// dimension (more for a wider MAX_WIDTH); input is stalled while it runs.
// When the receiver stalls, results queue in the pipeline and the output
// register; input stalls only once every stage is full.
// ----------------------------------------------------------------------------
module valid_2d_convolution #(
    parameter int MAX_KERNEL = v2dc_pkg::MAX_KERNEL_DEFAULT,
    parameter int MAX_WIDTH  = v2dc_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  v2dc_pkg::t_pixel_in                    i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output v2dc_pkg::t_result                      o_out_data,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [v2dc_pkg::CFG_ADDR_BITS-1:0]     paddr,
    input  logic [v2dc_pkg::CFG_DATA_BITS-1:0]     pwdata,
    output logic [v2dc_pkg::CFG_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    localparam int PB      = v2dc_pkg::PIXEL_BITS;
    localparam int CB      = v2dc_pkg::COEF_BITS;
    localparam int SB      = v2dc_pkg::SUM_BITS;
    localparam int IB      = v2dc_pkg::IDX_BITS;
    localparam int DB      = v2dc_pkg::DIM_BITS;
    localparam int KSB     = v2dc_pkg::KSIZE_BITS;
    localparam int DW      = v2dc_pkg::CFG_DATA_BITS;
    localparam int PROD_W  = PB + CB;
    localparam int SLOTS   = MAX_KERNEL - 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int LW      = (CW + 1 > DB) ? CW + 1 : DB;
    localparam int KW      = $clog2(MAX_KERNEL + 1);
    localparam int CNW     = $clog2(LW);
    localparam int CRW     = $clog2(v2dc_pkg::COEF_ROWS);
    localparam int CCW     = $clog2(v2dc_pkg::COEF_COLS);
    localparam int RAM_W   = SLOTS * PB;

    typedef struct packed {
        logic          emit;
        logic          err;
        logic          last;
        logic [IB-1:0] out_row;
        logic [IB-1:0] out_col;
    } t_meta;

    // ---------------------------------------------------------------- config
    logic [KSB-1:0] r_cfg_kr;
    logic [KSB-1:0] r_cfg_kc;
    logic [DB-1:0]  r_cfg_w;
    logic [DB-1:0]  r_cfg_h;
    logic [DW-1:0]  r_kern [v2dc_pkg::COEF_ROWS];

    logic               cfg_wr;
    v2dc_pkg::t_cfg_reg cfg_sel;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = v2dc_pkg::t_cfg_reg'(paddr[5:3]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_kr <= v2dc_pkg::KERNEL_ROWS_RESET;
            r_cfg_kc <= v2dc_pkg::KERNEL_COLS_RESET;
            r_cfg_w  <= v2dc_pkg::IMAGE_WIDTH_RESET;
            r_cfg_h  <= v2dc_pkg::IMAGE_HEIGHT_RESET;
            for (int i = 0; i < v2dc_pkg::COEF_ROWS; i++) begin
                r_kern[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_sel)
                v2dc_pkg::REG_KERNEL_ROWS:  r_cfg_kr  <= pwdata[KSB-1:0];
                v2dc_pkg::REG_KERNEL_COLS:  r_cfg_kc  <= pwdata[KSB-1:0];
                v2dc_pkg::REG_IMAGE_WIDTH:  r_cfg_w   <= pwdata[DB-1:0];
                v2dc_pkg::REG_IMAGE_HEIGHT: r_cfg_h   <= pwdata[DB-1:0];
                v2dc_pkg::REG_KERNEL_ROW_0: r_kern[0] <= pwdata;
                v2dc_pkg::REG_KERNEL_ROW_1: r_kern[1] <= pwdata;
                v2dc_pkg::REG_KERNEL_ROW_2: r_kern[2] <= pwdata;
                v2dc_pkg::REG_KERNEL_ROW_3: r_kern[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            v2dc_pkg::REG_KERNEL_ROWS:  prdata = DW'(r_cfg_kr);
            v2dc_pkg::REG_KERNEL_COLS:  prdata = DW'(r_cfg_kc);
            v2dc_pkg::REG_IMAGE_WIDTH:  prdata = DW'(r_cfg_w);
            v2dc_pkg::REG_IMAGE_HEIGHT: prdata = DW'(r_cfg_h);
            v2dc_pkg::REG_KERNEL_ROW_0: prdata = r_kern[0];
            v2dc_pkg::REG_KERNEL_ROW_1: prdata = r_kern[1];
            v2dc_pkg::REG_KERNEL_ROW_2: prdata = r_kern[2];
            v2dc_pkg::REG_KERNEL_ROW_3: prdata = r_kern[3];
            default:                    prdata = '0;
        endcase
    end

    // Out-of-range sizes are clamped into the supported range.
    logic [KW-1:0] kr_cl;
    logic [KW-1:0] kc_cl;
    logic [LW-1:0] w_cl;
    logic [DB-1:0] h_cl;

    always_comb begin
        if (r_cfg_kr == '0) begin
            kr_cl = KW'(1);
        end else if (int'(r_cfg_kr) > MAX_KERNEL) begin
            kr_cl = KW'(MAX_KERNEL);
        end else begin
            kr_cl = KW'(r_cfg_kr);
        end
        if (r_cfg_kc == '0) begin
            kc_cl = KW'(1);
        end else if (int'(r_cfg_kc) > MAX_KERNEL) begin
            kc_cl = KW'(MAX_KERNEL);
        end else begin
            kc_cl = KW'(r_cfg_kc);
        end
        if (r_cfg_w == '0) begin
            w_cl = LW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            w_cl = LW'(MAX_WIDTH);
        end else begin
            w_cl = LW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_cl = DB'(1);
        end else if (int'(r_cfg_h) > v2dc_pkg::MAX_HEIGHT) begin
            h_cl = DB'(v2dc_pkg::MAX_HEIGHT);
        end else begin
            h_cl = r_cfg_h;
        end
    end

    // ------------------------------------------------- divisibility check
    // Restoring remainder, one dividend bit per cycle, height and width in
    // parallel.
    logic           r_chk_busy;
    logic [CNW-1:0] r_chk_cnt;
    logic [KW-1:0]  r_rem_h;
    logic [KW-1:0]  r_rem_w;
    logic           r_cfg_bad;

    logic [CNW-1:0] chk_idx;
    logic [LW-1:0]  h_ext;
    logic [KW:0]    rem_h_sh;
    logic [KW:0]    rem_w_sh;
    logic [KW-1:0]  n_rem_h;
    logic [KW-1:0]  n_rem_w;

    always_comb begin
        h_ext    = LW'(h_cl);
        chk_idx  = CNW'(LW - 1) - r_chk_cnt;
        rem_h_sh = {r_rem_h, h_ext[chk_idx]};
        rem_w_sh = {r_rem_w, w_cl[chk_idx]};
        if (rem_h_sh >= {1'b0, kr_cl}) begin
            n_rem_h = KW'(rem_h_sh - {1'b0, kr_cl});
        end else begin
            n_rem_h = KW'(rem_h_sh);
        end
        if (rem_w_sh >= {1'b0, kc_cl}) begin
            n_rem_w = KW'(rem_w_sh - {1'b0, kc_cl});
        end else begin
            n_rem_w = KW'(rem_w_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_busy <= 1'b1;
            r_chk_cnt  <= '0;
            r_rem_h    <= '0;
            r_rem_w    <= '0;
            r_cfg_bad  <= 1'b0;
        end else if (cfg_wr) begin
            r_chk_busy <= 1'b1;
            r_chk_cnt  <= '0;
            r_rem_h    <= '0;
            r_rem_w    <= '0;
        end else if (r_chk_busy) begin
            r_rem_h   <= n_rem_h;
            r_rem_w   <= n_rem_w;
            r_chk_cnt <= r_chk_cnt + CNW'(1);
            if (r_chk_cnt == CNW'(LW - 1)) begin
                r_chk_busy <= 1'b0;
                r_cfg_bad  <= (n_rem_h != '0) || (n_rem_w != '0);
            end
        end
    end

    // ------------------------------------------------------ pipeline control
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_out_valid;
    logic en1, en2, en3, en4, out_free, res4, accept;

    t_meta r_s1_meta, r_s2_meta, r_s3_meta, r_s4_meta;

    always_comb begin
        res4       = r_s4_meta.emit || r_s4_meta.err;
        out_free   = !r_out_valid || !i_out_stall;
        en4        = !r_v4 || !res4 || out_free;
        en3        = !r_v3 || en4;
        en2        = !r_v2 || en3;
        en1        = !r_v1 || en2;
        o_in_stall = r_chk_busy || !en1;
        accept     = i_in_valid && !o_in_stall;
    end

    // ------------------------------------------------ stage 0: position
    logic [IB-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [SLOT_W-1:0] r_slot;
    logic              r_fe;

    logic [IB-1:0]     p_row;
    logic [CW-1:0]     p_col;
    logic [SLOT_W-1:0] p_slot;
    logic              p_fe;
    logic [LW-1:0]     row_ext, col_ext, kr_ext, kc_ext, row_inc, col_inc;
    logic [LW-1:0]     orow_ext, ocol_ext;
    logic [IB-1:0]     n_row;
    logic [CW-1:0]     n_col;
    logic [SLOT_W-1:0] n_slot;
    t_meta             meta0;

    always_comb begin
        if (i_in_data.frame_start) begin
            p_row  = '0;
            p_col  = '0;
            p_slot = '0;
            p_fe   = r_cfg_bad;
        end else begin
            p_row  = r_row;
            p_col  = r_col;
            p_slot = r_slot;
            p_fe   = r_fe;
        end
        row_ext  = LW'(p_row);
        col_ext  = LW'(p_col);
        kr_ext   = LW'(kr_cl);
        kc_ext   = LW'(kc_cl);
        row_inc  = row_ext + LW'(1);
        col_inc  = col_ext + LW'(1);
        orow_ext = row_ext - (kr_ext - LW'(1));
        ocol_ext = col_ext - (kc_ext - LW'(1));

        meta0.err  = i_in_data.frame_start && r_cfg_bad;
        meta0.emit = !p_fe && (row_inc >= kr_ext) && (col_inc >= kc_ext);
        if (meta0.err) begin
            meta0.last    = 1'b1;
            meta0.out_row = '0;
            meta0.out_col = '0;
        end else begin
            meta0.last    = (row_inc == LW'(h_cl)) && (col_inc == w_cl);
            meta0.out_row = orow_ext[IB-1:0];
            meta0.out_col = ocol_ext[IB-1:0];
        end

        if (col_inc >= w_cl) begin
            n_col = '0;
            if (row_inc >= LW'(h_cl)) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = row_inc[IB-1:0];
                n_slot = (p_slot == SLOT_W'(SLOTS - 1)) ? '0 : p_slot + SLOT_W'(1);
            end
        end else begin
            n_col  = col_inc[CW-1:0];
            n_row  = p_row;
            n_slot = p_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
            r_fe   <= 1'b0;
        end else if (accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
            r_fe   <= p_fe;
        end
    end

    // ---------------------------------------- stage 1: line store RMW
    logic signed [PB-1:0] r_s1_px;
    logic [CW-1:0]        r_s1_col;
    logic [SLOT_W-1:0]    r_s1_slot;

    logic                 r_fwd_v;
    logic [CW-1:0]        r_fwd_addr;
    logic [RAM_W-1:0]     r_fwd_data;

    logic [RAM_W-1:0]     ram_rdata;
    logic [RAM_W-1:0]     word;
    logic [RAM_W-1:0]     merged;
    logic signed [PB-1:0] col_new [MAX_KERNEL];
    logic                 s1_move;
    int                   sidx;

    v2dc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_col),
        .i_wdata (merged),
        .i_re    (accept),
        .i_raddr (p_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        s1_move = r_v1 && en2;
        // The word written at the edge that issued this read is not in the
        // RAM output yet, so take it from the forwarding register.
        if (r_fwd_v && (r_fwd_addr == r_s1_col)) begin
            word = r_fwd_data;
        end else begin
            word = ram_rdata;
        end
        merged = word;
        for (int s = 0; s < SLOTS; s++) begin
            if (SLOT_W'(s) == r_s1_slot) begin
                merged[s*PB +: PB] = r_s1_px;
            end
        end
        for (int d = 1; d < MAX_KERNEL; d++) begin
            sidx = int'(r_s1_slot) + SLOTS - d;
            if (sidx >= SLOTS) begin
                sidx = sidx - SLOTS;
            end
            col_new[MAX_KERNEL-1-d] = word[sidx*PB +: PB];
        end
        col_new[MAX_KERNEL-1] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (accept) begin
                r_fwd_v <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px    <= i_in_data.pixel;
            r_s1_col   <= p_col;
            r_s1_slot  <= p_slot;
            r_s1_meta  <= meta0;
            r_fwd_addr <= r_s1_col;
            r_fwd_data <= merged;
        end
    end

    // ------------------------------------------- stage 2: window, products
    logic signed [PB-1:0]     r_win  [MAX_KERNEL][MAX_KERNEL];
    logic signed [CB-1:0]     coef_sel [MAX_KERNEL][MAX_KERNEL];
    logic                     coef_used [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] r_prod [MAX_KERNEL][MAX_KERNEL];
    int                       ci, cj;

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            for (int a = 0; a < MAX_KERNEL; a++) begin
                for (int b = 0; b < MAX_KERNEL - 1; b++) begin
                    r_win[a][b] <= r_win[a][b+1];
                end
                r_win[a][MAX_KERNEL-1] <= col_new[a];
            end
        end
    end

    // Kernel element (i, j) lines up with window position
    // (MAX_KERNEL-kr+i, MAX_KERNEL-kc+j); the rest of the window gets zero.
    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            for (int b = 0; b < MAX_KERNEL; b++) begin
                ci = a + int'(kr_cl) - MAX_KERNEL;
                cj = b + int'(kc_cl) - MAX_KERNEL;
                if (ci >= 0 && cj >= 0 && ci < v2dc_pkg::COEF_ROWS
                    && cj < v2dc_pkg::COEF_COLS) begin
                    coef_sel[a][b]  = r_kern[CRW'(ci)][int'(CCW'(cj))*CB +: CB];
                    coef_used[a][b] = 1'b1;
                end else begin
                    coef_sel[a][b]  = '0;
                    coef_used[a][b] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    // Window positions outside the kernel can hold rows that were never
    // stored, so their products are forced to zero rather than multiplied.
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_meta <= r_s2_meta;
            for (int a = 0; a < MAX_KERNEL; a++) begin
                for (int b = 0; b < MAX_KERNEL; b++) begin
                    if (coef_used[a][b]) begin
                        r_prod[a][b] <= r_win[a][b] * coef_sel[a][b];
                    end else begin
                        r_prod[a][b] <= '0;
                    end
                end
            end
        end
    end

    // ------------------------------------------------ stage 3: row sums
    logic signed [SB-1:0] r_rowsum [MAX_KERNEL];
    logic signed [SB-1:0] rowsum   [MAX_KERNEL];
    logic signed [SB-1:0] total;

    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            rowsum[a] = '0;
            for (int b = 0; b < MAX_KERNEL; b++) begin
                rowsum[a] = rowsum[a]
                          + {{(SB-PROD_W){r_prod[a][b][PROD_W-1]}}, r_prod[a][b]};
            end
        end
        total = '0;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            total = total + r_rowsum[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_meta <= r_s3_meta;
            for (int a = 0; a < MAX_KERNEL; a++) begin
                r_rowsum[a] <= rowsum[a];
            end
        end
    end

    // ------------------------------------------------ stage 4: output
    v2dc_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_v4 && res4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out.sum     <= r_s4_meta.err ? '0 : total;
            r_out.out_row <= r_s4_meta.out_row;
            r_out.out_col <= r_s4_meta.out_col;
            r_out.last    <= r_s4_meta.last;
            r_out.error   <= r_s4_meta.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: bench/v2dc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid 2D convolution checker
// Follows register writes on the APB port, predicts the result of every pixel
// transfer with its own line store and window, and compares each result
// transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module v2dc_checker
    import v2dc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  t_pixel_in                i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  t_result                  i_out_data,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic                     i_pready,
    input  logic [CFG_ADDR_BITS-1:0] i_paddr,
    input  logic [CFG_DATA_BITS-1:0] i_pwdata,
    input  logic                     i_end_check,
    output int                       o_pending,
    output int                       o_fail_count
);

    localparam int KMAX         = MAX_KERNEL_DEFAULT;
    localparam int STORE_ROWS   = KMAX - 1;
    localparam int STORE_COLS   = MAX_WIDTH_DEFAULT;
    localparam int REPORT_LIMIT = 100;

    logic [KSIZE_BITS-1:0]        cfg_rows;
    logic [KSIZE_BITS-1:0]        cfg_cols;
    logic [DIM_BITS-1:0]          cfg_width;
    logic [DIM_BITS-1:0]          cfg_height;
    logic [CFG_DATA_BITS-1:0]     cfg_kernel [COEF_ROWS];
    logic signed [PIXEL_BITS-1:0] line_mem [STORE_ROWS*STORE_COLS];
    logic signed [PIXEL_BITS-1:0] win [KMAX][KMAX];
    int unsigned                  row_pos;
    int unsigned                  col_pos;
    bit                           frame_bad;
    t_result                      awaited_results [$];
    int                           fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic reset_model();
        row_pos    = 0;
        col_pos    = 0;
        frame_bad  = 1'b0;
        cfg_rows   = KERNEL_ROWS_RESET;
        cfg_cols   = KERNEL_COLS_RESET;
        cfg_width  = IMAGE_WIDTH_RESET;
        cfg_height = IMAGE_HEIGHT_RESET;
        for (int i = 0; i < COEF_ROWS; i++) cfg_kernel[i] = '0;
        for (int i = 0; i < STORE_ROWS*STORE_COLS; i++) line_mem[i] = '0;
        for (int i = 0; i < KMAX; i++) begin
            for (int j = 0; j < KMAX; j++) win[i][j] = '0;
        end
        awaited_results.delete();
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_KERNEL_ROWS:  cfg_rows   = data[KSIZE_BITS-1:0];
            REG_KERNEL_COLS:  cfg_cols   = data[KSIZE_BITS-1:0];
            REG_IMAGE_WIDTH:  cfg_width  = data[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT: cfg_height = data[DIM_BITS-1:0];
            default:          cfg_kernel[idx - REG_KERNEL_ROW_0] = data;
        endcase
    endtask

    // Advances the position by one pixel and returns 1 when the pixel yields a result.
    function automatic bit convolve_pixel(input t_pixel_in item, output t_result res);
        int unsigned                  kr, kc, w, h, r, c, slot;
        logic signed [PIXEL_BITS-1:0] col_new [KMAX];
        logic signed [COEF_BITS-1:0]  coef;
        longint                       acc;
        bit                           hit;
        kr  = clamp_to(cfg_rows, KMAX);
        kc  = clamp_to(cfg_cols, KMAX);
        w   = clamp_to(cfg_width, STORE_COLS);
        h   = clamp_to(cfg_height, MAX_HEIGHT);
        hit = 1'b0;
        res = '0;
        if (item.frame_start) begin
            row_pos   = 0;
            col_pos   = 0;
            frame_bad = (h % kr != 0) || (w % kc != 0);
            if (frame_bad) begin
                res.last  = 1'b1;
                res.error = 1'b1;
                hit       = 1'b1;
            end
        end
        r = row_pos;
        c = col_pos;
        // Row r-d of the image lives in store slot (r-d) mod STORE_ROWS.
        for (int d = 1; d < KMAX; d++) begin
            slot = (r % STORE_ROWS + STORE_ROWS - d % STORE_ROWS) % STORE_ROWS;
            col_new[KMAX-1-d] = line_mem[slot*STORE_COLS + c];
        end
        col_new[KMAX-1] = item.pixel;
        line_mem[(r % STORE_ROWS)*STORE_COLS + c] = item.pixel;
        for (int i = 0; i < KMAX; i++) begin
            for (int j = 0; j < KMAX-1; j++) win[i][j] = win[i][j+1];
            win[i][KMAX-1] = col_new[i];
        end
        if (!frame_bad && r + 1 >= kr && c + 1 >= kc) begin
            acc = 0;
            for (int i = 0; i < kr; i++) begin
                for (int j = 0; j < kc; j++) begin
                    coef = cfg_kernel[i][COEF_BITS*j +: COEF_BITS];
                    acc += longint'(win[KMAX-kr+i][KMAX-kc+j]) * longint'(coef);
                end
            end
            res.sum     = SUM_BITS'(acc);
            res.out_row = IDX_BITS'(r - (kr - 1));
            res.out_col = IDX_BITS'(c - (kc - 1));
            res.last    = (r + 1 == h) && (c + 1 == w);
            res.error   = 1'b0;
            hit         = 1'b1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
        return hit;
    endfunction

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got, input t_result tag);
        if (want !== got) begin
            report_mismatch($sformatf("%s at row %0d col %0d: expected %0d, got %0d",
                                      name, tag.out_row, tag.out_col, want, got));
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result transfer at row %0d col %0d",
                                      got.out_row, got.out_col));
            return;
        end
        want = awaited_results.pop_front();
        compare_field("sum", want.sum, got.sum, want);
        compare_field("out_row", want.out_row, got.out_row, want);
        compare_field("out_col", want.out_col, got.out_col, want);
        compare_field("last", want.last, got.last, want);
        compare_field("error", want.error, got.error, want);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result predicted;
        t_result missing;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                write_register(t_cfg_reg'(i_paddr[CFG_ADDR_BITS-1 -: 3]), i_pwdata);
            end
            if (i_in_valid && !i_in_stall) begin
                if (convolve_pixel(i_in_data, predicted)) awaited_results.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_data);
            end
            if (i_end_check) begin
                while (awaited_results.size() > 0) begin
                    missing = awaited_results.pop_front();
                    report_mismatch($sformatf("result at row %0d col %0d never transferred",
                                              missing.out_row, missing.out_col));
                end
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid 2D convolution testbench
// Drives pixel frames and kernel settings into the block with random gaps and
// result stalls; a checker beside the block predicts and compares every sum.
// ----------------------------------------------------------------------------
module tb_top;

    import v2dc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int MAX_PHASE_PIX  = 260;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    t_pixel_in                in_data;
    logic                     out_valid;
    logic                     out_stall;
    t_result                  out_data;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic                     pready;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     end_check;
    int                       pending;
    int                       fail_count;
    int                       idle_cycles = 0;
    int                       random_count = 0;
    bit                       in_quiet = 1'b0;
    bit                       out_quiet = 1'b0;

    valid_2d_convolution DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    v2dc_checker u_conv_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_end_check  (end_check),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall) ||
                       (psel && penable))) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            idle_cycles <= 0;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Result side: every transfer is preceded by a random number of stall cycles.
    initial begin : result_sink
        int hold;
        out_stall <= 1'b1;
        do @(posedge clk); while (!rst_n);
        forever begin
            hold = draw_wait(out_quiet);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic logic signed [PIXEL_BITS-1:0] random_q88();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_ROWS*CFG_DATA_BITS-1:0] random_kernel();
        logic [COEF_ROWS*CFG_DATA_BITS-1:0] k;
        for (int i = 0; i < COEF_ROWS*COEF_COLS; i++) k[COEF_BITS*i +: COEF_BITS] = random_q88();
        return k;
    endfunction

    function automatic int clamp_dim(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic send_pixel(input logic signed [PIXEL_BITS-1:0] px, input logic fs);
        int gap;
        gap = draw_wait(in_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {px, fs};
        do @(posedge clk); while (in_stall);
    endtask

    // Holds off input until every predicted result has been transferred,
    // then lets the pipeline run empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic configure(input logic [KSIZE_BITS-1:0] rows, input logic [KSIZE_BITS-1:0] cols,
                             input logic [DIM_BITS-1:0] width, input logic [DIM_BITS-1:0] height,
                             input logic [COEF_ROWS*CFG_DATA_BITS-1:0] kernel);
        wait_drained();
        write_register(REG_KERNEL_ROWS, CFG_DATA_BITS'(rows));
        write_register(REG_KERNEL_COLS, CFG_DATA_BITS'(cols));
        write_register(REG_IMAGE_WIDTH, CFG_DATA_BITS'(width));
        write_register(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(height));
        for (int i = 0; i < COEF_ROWS; i++) begin
            write_register(t_cfg_reg'(REG_KERNEL_ROW_0 + i), kernel[CFG_DATA_BITS*i +: CFG_DATA_BITS]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly whole frames; some frames run on without a frame start and a few
    // are cut short by an early one.
    task automatic run_phase(input int rows, input int cols, input int width, input int height,
                             input int count);
        int   frame_px;
        int   pos;
        logic fs;
        configure(KSIZE_BITS'(rows), KSIZE_BITS'(cols), DIM_BITS'(width), DIM_BITS'(height),
                  random_kernel());
        frame_px  = clamp_dim(width, MAX_WIDTH_DEFAULT) * clamp_dim(height, MAX_HEIGHT);
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
        pos       = 0;
        for (int n = 0; n < count; n++) begin
            if (n == 0) fs = 1'b1;
            else if (pos == 0) fs = ($urandom_range(0, 3) != 0);
            else fs = ($urandom_range(0, 24) == 0);
            if (fs) pos = 0;
            if (n > 0 && $urandom_range(0, 149) == 0) wait_drained();
            send_pixel(random_q88(), fs);
            pos = (pos + 1) % frame_px;
        end
        random_count += count;
    endtask

    initial begin : stimulus
        int kr, kc, w, h, count;
        in_valid  <= 1'b0;
        in_data   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        end_check <= 1'b0;
        rst_n     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Most negative pixels and coefficients; the first frame arrives
        // without a frame start, straight from the reset position.
        configure(3'd2, 3'd2, 11'd2, 11'd2,
                  (random_kernel() << (2*CFG_DATA_BITS))
                  | {{(2*CFG_DATA_BITS){1'b0}}, {2*COEF_COLS{16'h8000}}});
        for (int i = 0; i < 4; i++) send_pixel(16'sh8000, 1'b0);
        send_pixel(16'sh7fff, 1'b1);
        send_pixel(16'sh8000, 1'b0);
        send_pixel('0, 1'b0);
        send_pixel(16'sh7fff, 1'b0);

        // Full 4x4 kernel of largest coefficients over a single-window image.
        configure(3'd4, 3'd4, 11'd4, 11'd4, {COEF_ROWS*COEF_COLS{16'h7fff}});
        for (int i = 0; i < 16; i++) send_pixel((i % 5 == 0) ? 16'sh7fff : 16'sh8000, i == 0);

        // Width not a multiple of the kernel width: one error result, then silence.
        configure(3'd3, 3'd2, 11'd5, 11'd3, random_kernel());
        send_pixel(random_q88(), 1'b1);
        send_pixel(random_q88(), 1'b0);
        send_pixel(random_q88(), 1'b0);

        // One phase over the widest rows, with width and height values that may lie out of range.
        case ($urandom_range(0, 3))
            0:       h = 0;
            1:       h = 1;
            2:       h = 1024;
            default: h = 2047;
        endcase
        run_phase($urandom_range(0, 1), 1 << $urandom_range(0, 2), $urandom_range(1024, 2047), h,
                  1024 + $urandom_range(0, 40));

        while (random_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                // Any kernel size register value, image sizes mostly small and often not divisible.
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(1024, 2047) : $urandom_range(0, 12);
                run_phase($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 12), h,
                          $urandom_range(20, 80));
            end else begin
                kr    = $urandom_range(1, 4);
                kc    = $urandom_range(1, 4);
                w     = kc * $urandom_range(1, 4);
                h     = kr * $urandom_range(1, 4);
                count = w * h * $urandom_range(1, 3);
                if (count > MAX_PHASE_PIX) count = MAX_PHASE_PIX;
                run_phase(kr, kc, w, h, count);
            end
        end

        wait_drained();
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
